### hdl/radial_occupancy_histogrammer_defines.svh
// ----------------------------------------------------------------------------
// Radial occupancy histogrammer assertion macros
// Shared assertion forms for the histogrammer RTL.
// ----------------------------------------------------------------------------
`ifndef RADIAL_OCCUPANCY_HISTOGRAMMER_DEFINES_SVH
`define RADIAL_OCCUPANCY_HISTOGRAMMER_DEFINES_SVH

`define ROH_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

`define ROH_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### hdl/roh_pkg.sv
// ----------------------------------------------------------------------------
// Radial occupancy histogrammer package
// Defaults, command and register codes, controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package roh_pkg;
  localparam int NUM_LAYERS_DEF = 16;
  localparam int MAX_BINS_DEF   = 64;

  localparam logic [1:0] CMD_HIT    = 2'd0;
  localparam logic [1:0] CMD_EOE    = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [3:0] REG_THRESHOLD = 4'd0;
  localparam logic [3:0] REG_MIN_RAD   = 4'd1;
  localparam logic [3:0] REG_SCALE     = 4'd2;
  localparam logic [3:0] REG_BINS      = 4'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_MUL, ST_BIN,
    ST_HRD, ST_HWR, ST_SWEEP, ST_SWEND, ST_RRD, ST_RRES
  } state_t;
endpackage
`default_nettype wire

### hdl/radial_occupancy_histogrammer.sv
// Hit: two squares, 20 root steps, scale multiply, bin, read, write.
// End of event: sweeps every table entry, one table entry per cycle.
// Read: the result word is taken from the registered sums memory read port.
// One word at a time; in_stall is high until the word is finished.
// After reset a clearing pass over all NUM_LAYERS*(MAX_BINS+2) table entries runs first.
// ----------------------------------------------------------------------------
// Radial occupancy histogrammer
// Per-event layer/radius counts folded into saturating sums in memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "radial_occupancy_histogrammer_defines.svh"
module radial_occupancy_histogrammer #(
  parameter int NUM_LAYERS = roh_pkg::NUM_LAYERS_DEF,
  parameter int MAX_BINS   = roh_pkg::MAX_BINS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [15:0]        hit_energy,
  input  wire logic signed [19:0] pos_x,
  input  wire logic signed [19:0] pos_y,
  input  wire logic [5:0]         layer_index,
  input  wire logic [6:0]         read_bin,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             count_sum,
  output logic [47:0]             count_square_sum,
  output logic [31:0]             events_seen
);
  localparam int ROW_LEN   = MAX_BINS + 2;
  localparam int TABLE_LEN = NUM_LAYERS * ROW_LEN;
  localparam int AW        = $clog2(TABLE_LEN);
  localparam int BW        = $clog2(ROW_LEN);

  roh_pkg::state_t state, state_next;

  logic [15:0] energy_threshold;
  logic [19:0] min_radius;
  logic [23:0] bin_scale;
  logic [6:0]  bins_in_use;

  logic [1:0]  cmd_q;
  logic [19:0] x_q, y_q;
  logic [5:0]  layer_q;
  logic [6:0]  rbin_q;

  logic [39:0] rem, root;
  logic [4:0]  it;
  logic        below;
  logic [43:0] prod;
  logic [AW-1:0] hit_addr;
  logic [AW-1:0] sw_addr;
  logic [BW-1:0] sw_bin;
  logic          wb_valid, wb_use;
  logic [AW-1:0] wb_addr;
  logic          rd_ok;
  logic [31:0]   event_total;

  logic [15:0] cmem [TABLE_LEN];
  logic [79:0] smem [TABLE_LEN];
  logic [15:0] cnt_q;
  logic [79:0] sums_q;

  logic          cw_en, cr_en, sw_en, sr_en;
  logic [AW-1:0] cw_addr, cr_addr, sw_a, sr_addr;
  logic [15:0]   cw_data;
  logic [79:0]   sw_data;

  logic        accept;
  logic [19:0] ax, ay;
  logic [39:0] bitv, trial;
  logic [8:0]  nb_wide;
  logic [BW-1:0] nb;
  logic [27:0] kval;
  logic [BW-1:0] bin;
  logic        hit_ok, read_in_range;
  logic [32:0] s_sum;
  logic [31:0] c_sq;
  logic [48:0] s_sq;
  logic [31:0] new_sum;
  logic [47:0] new_sq;
  logic        load_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != roh_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;

  assign ax    = x_q[19] ? (~x_q + 20'd1) : x_q;
  assign ay    = y_q[19] ? (~y_q + 20'd1) : y_q;
  assign bitv  = 40'd1 << {it, 1'b0};
  assign trial = root + bitv;

  assign nb_wide = (bins_in_use == 7'd0) ? 9'd1 :
                   ({2'b0, bins_in_use} > 9'(MAX_BINS)) ? 9'(MAX_BINS) :
                   {2'b0, bins_in_use};
  assign nb   = BW'(nb_wide);
  assign kval = prod[43:16];
  assign bin  = below ? '0 : (kval < 28'(nb)) ? (BW'(kval) + BW'(1)) : (nb + BW'(1));

  assign hit_ok = (hit_energy > energy_threshold) && ({1'b0, layer_index} < 7'(NUM_LAYERS));
  assign read_in_range = ({1'b0, layer_q} < 7'(NUM_LAYERS)) &&
                         ({2'b0, rbin_q} <= 9'(MAX_BINS + 1));

  assign s_sum   = {1'b0, sums_q[31:0]} + 33'(cnt_q);
  assign c_sq    = cnt_q * cnt_q;
  assign s_sq    = {1'b0, sums_q[79:32]} + 49'(c_sq);
  assign new_sum = s_sum[32] ? '1 : s_sum[31:0];
  assign new_sq  = s_sq[48] ? '1 : s_sq[47:0];

  assign load_out = (state == roh_pkg::ST_RRES) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      roh_pkg::ST_CLEAR: if (sw_addr == AW'(TABLE_LEN - 1)) state_next = roh_pkg::ST_IDLE;
      roh_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (command)
            roh_pkg::CMD_HIT:  state_next = hit_ok ? roh_pkg::ST_SQX : roh_pkg::ST_IDLE;
            roh_pkg::CMD_EOE:  state_next = roh_pkg::ST_SWEEP;
            roh_pkg::CMD_READ: state_next = roh_pkg::ST_RRD;
            default:           state_next = roh_pkg::ST_IDLE;
          endcase
        end
      end
      roh_pkg::ST_SQX:   state_next = roh_pkg::ST_SQY;
      roh_pkg::ST_SQY:   state_next = roh_pkg::ST_ROOT;
      roh_pkg::ST_ROOT:  if (it == 5'd0) state_next = roh_pkg::ST_MUL;
      roh_pkg::ST_MUL:   state_next = roh_pkg::ST_BIN;
      roh_pkg::ST_BIN:   state_next = roh_pkg::ST_HRD;
      roh_pkg::ST_HRD:   state_next = roh_pkg::ST_HWR;
      roh_pkg::ST_HWR:   state_next = roh_pkg::ST_IDLE;
      roh_pkg::ST_SWEEP: if (sw_addr == AW'(TABLE_LEN - 1)) state_next = roh_pkg::ST_SWEND;
      roh_pkg::ST_SWEND: state_next = roh_pkg::ST_IDLE;
      roh_pkg::ST_RRD:   state_next = roh_pkg::ST_RRES;
      roh_pkg::ST_RRES:  if (load_out) state_next = roh_pkg::ST_IDLE;
      default:           state_next = roh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cw_en = 1'b0; cw_addr = wb_addr; cw_data = '0;
    cr_en = 1'b0; cr_addr = sw_addr;
    sw_en = 1'b0; sw_a = wb_addr; sw_data = {new_sq, new_sum};
    sr_en = 1'b0; sr_addr = sw_addr;
    if (state == roh_pkg::ST_CLEAR) begin
      cw_en = 1'b1; cw_addr = sw_addr;
      sw_en = 1'b1; sw_a = sw_addr; sw_data = '0;
    end
    if (state == roh_pkg::ST_SWEEP) begin
      cr_en = 1'b1;
      sr_en = 1'b1;
    end
    if (wb_valid) begin
      cw_en = 1'b1;
      sw_en = wb_use;
    end
    if (state == roh_pkg::ST_HRD) begin
      cr_en = 1'b1; cr_addr = hit_addr;
    end
    if (state == roh_pkg::ST_HWR) begin
      cw_en = 1'b1; cw_addr = hit_addr;
      cw_data = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
    end
    if (state == roh_pkg::ST_RRD && read_in_range) begin
      sr_en = 1'b1;
      sr_addr = AW'(layer_q) * AW'(ROW_LEN) + AW'(rbin_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) cmem[cw_addr] <= cw_data;
    if (cr_en) cnt_q <= cmem[cr_addr];
    if (sw_en) smem[sw_a] <= sw_data;
    if (sr_en) sums_q <= smem[sr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= roh_pkg::ST_CLEAR;
      energy_threshold <= '0;
      min_radius       <= '0;
      bin_scale        <= 24'd65536;
      bins_in_use      <= 7'd64;
      sw_addr          <= '0;
      sw_bin           <= '0;
      wb_valid         <= 1'b0;
      event_total      <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          roh_pkg::REG_THRESHOLD: energy_threshold <= cfg_data[15:0];
          roh_pkg::REG_MIN_RAD:   min_radius       <= cfg_data[19:0];
          roh_pkg::REG_SCALE:     bin_scale        <= cfg_data;
          roh_pkg::REG_BINS:      bins_in_use      <= cfg_data[6:0];
          default: ;
        endcase
      end
      wb_valid <= (state == roh_pkg::ST_SWEEP);
      if (state == roh_pkg::ST_CLEAR || state == roh_pkg::ST_SWEEP) begin
        sw_addr <= (sw_addr == AW'(TABLE_LEN - 1)) ? '0 : sw_addr + AW'(1);
        sw_bin  <= (sw_bin == BW'(ROW_LEN - 1)) ? '0 : sw_bin + BW'(1);
      end
      if (state == roh_pkg::ST_IDLE) begin
        sw_addr <= '0;
        sw_bin  <= '0;
      end
      if (state == roh_pkg::ST_SWEND && event_total != '1) event_total <= event_total + 32'd1;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command; x_q <= pos_x; y_q <= pos_y;
      layer_q <= layer_index; rbin_q <= read_bin;
    end
    wb_addr <= sw_addr;
    wb_use  <= (sw_bin != '0) && (sw_bin <= nb);
    unique case (state)
      roh_pkg::ST_SQX: rem <= ax * ax;
      roh_pkg::ST_SQY: begin
        rem  <= rem + ay * ay;
        root <= '0;
        it   <= 5'd19;
      end
      roh_pkg::ST_ROOT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        it <= it - 5'd1;
      end
      roh_pkg::ST_MUL: begin
        below <= (root[19:0] < min_radius);
        prod  <= (root[19:0] - min_radius) * bin_scale;
      end
      roh_pkg::ST_BIN: hit_addr <= AW'(layer_q) * AW'(ROW_LEN) + AW'(bin);
      roh_pkg::ST_RRD: rd_ok <= read_in_range;
      default: ;
    endcase
    if (load_out) begin
      count_sum        <= rd_ok ? sums_q[31:0] : '0;
      count_square_sum <= rd_ok ? sums_q[79:32] : '0;
      events_seen      <= event_total;
    end
  end

  `ROH_ASSERT_NOW(a_busy_stalls, clk, rst, state != roh_pkg::ST_IDLE, in_stall)
  `ROH_ASSERT_NOW(a_out_from_read, clk, rst, $rose(out_valid), $past(state) == roh_pkg::ST_RRES)
  `ROH_ASSERT_NEXT(a_sweep_writes, clk, rst, state == roh_pkg::ST_SWEEP, wb_valid)
  `ROH_ASSERT_NOW(a_hit_cmd, clk, rst, state == roh_pkg::ST_SQX, cmd_q == roh_pkg::CMD_HIT)
endmodule
`default_nettype wire
